### rtl/core/pmcs_pkg.sv
// shared types, constants and helpers for the per-mode current statistics block
package pmcs_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int COUNT_BITS  = 32;
	localparam int BINS        = 6;
	localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
	localparam int THRESH_BITS = 24;
	localparam int PERIOD_BITS = 16;
	localparam int TIME_BITS   = 32;
	localparam int DUR_BITS    = 32;
	localparam int CFG_BITS    = 24;
	localparam int STEP_BITS   = $clog2(SAMPLE_BITS);

	localparam logic [STEP_BITS-1:0]  STEP_LAST  = STEP_BITS'(SAMPLE_BITS - 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};

	// reset values of the configuration registers
	localparam logic signed [THRESH_BITS-1:0] CUTOFF_RESET = THRESH_BITS'(100);
	localparam logic [PERIOD_BITS-1:0]        SUMMIN_RESET = PERIOD_BITS'(8);
	localparam logic [PERIOD_BITS-1:0]        PERIOD_RESET = PERIOD_BITS'(100);

	// configuration register indexes
	localparam logic [1:0] REG_CUTOFF = 2'd0;
	localparam logic [1:0] REG_SUMMIN = 2'd1;
	localparam logic [1:0] REG_PERIOD = 2'd2;

	// system modes
	localparam logic [2:0] MODE_MUTED = 3'd1;
	localparam logic [2:0] MODE_LOW   = 3'd2;
	localparam logic [2:0] MODE_DIAG  = 3'd3;
	localparam logic [2:0] MODE_FAULT = 3'd4;

	// bin codes
	localparam logic [2:0] CAT_ACTIVE    = 3'd0;
	localparam logic [2:0] CAT_HEAD_DOWN = 3'd1;
	localparam logic [2:0] CAT_MUTED     = 3'd2;
	localparam logic [2:0] CAT_LOW_POWER = 3'd3;
	localparam logic [2:0] CAT_DIAG      = 3'd4;
	localparam logic [2:0] CAT_FAULT     = 3'd5;

	// divider slots: the sample's own bin, then low power, head down, active
	typedef logic [1:0] slot_t;
	localparam slot_t SLOT_BIN = 2'd0;
	localparam slot_t SLOT_LP  = 2'd1;
	localparam slot_t SLOT_HD  = 2'd2;
	localparam slot_t SLOT_AC  = 2'd3;

	typedef struct packed {
		logic [2:0]                      system_mode;
		logic                            head_lowered;
		logic signed [SAMPLE_BITS-1:0]   current_sample;
		logic [TIME_BITS-1:0]            time_ms;
	} sample_word_t;

	typedef struct packed {
		logic [2:0]                      category;
		logic signed [SAMPLE_BITS-1:0]   bin_min;
		logic signed [SAMPLE_BITS-1:0]   bin_max;
		logic signed [SAMPLE_BITS-1:0]   bin_average;
		logic [COUNT_BITS-1:0]           bin_count;
		logic [DUR_BITS-1:0]             duration_ms;
		logic [TIME_BITS-1:0]            first_time;
		logic                            summary_due;
		logic                            cutoff_known;
		logic                            lp_cutoff_ok;
		logic                            mute_known;
		logic                            mute_pass;
	} result_word_t;

	typedef struct packed {
		logic  accept;
		logic  update;
		logic  load;
		logic  step;
		logic  save;
		logic  emit;
		slot_t slot;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

	function automatic logic [2:0] pick_bin(input logic [2:0] mode, input logic head);
		logic [2:0] b;
		case (mode)
			MODE_MUTED: b = CAT_MUTED;
			MODE_LOW:   b = CAT_LOW_POWER;
			MODE_DIAG:  b = CAT_DIAG;
			MODE_FAULT: b = CAT_FAULT;
			default:    b = head ? CAT_HEAD_DOWN : CAT_ACTIVE;
		endcase
		return b;
	endfunction

endpackage

### rtl/core/pmcs_ctrl.sv
// sequencer: update, four averages through the shared divider, result load
module pmcs_ctrl
	import pmcs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       sample_valid,
	output logic       sample_stall,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_UPD  = 6'b000010,
		ST_LOAD = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_SAVE = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t               state_q;
	slot_t                slot_q;
	logic [STEP_BITS-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q  <= SLOT_BIN;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (sample_valid) begin
						state_q <= ST_UPD;
						slot_q  <= SLOT_BIN;
					end
				end
				ST_UPD: state_q <= ST_LOAD;
				ST_LOAD: begin
					state_q <= ST_DIV;
					step_q  <= '0;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_LAST) state_q <= ST_SAVE;
				end
				ST_SAVE: begin
					if (slot_q == SLOT_AC) begin
						state_q <= ST_OUT;
					end else begin
						slot_q  <= slot_q + 1'b1;
						state_q <= ST_LOAD;
					end
				end
				ST_OUT: begin
					if (status.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign sample_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.slot   = slot_q;
		cmd.accept = (state_q == ST_IDLE) && sample_valid;
		cmd.update = (state_q == ST_UPD);
		cmd.load   = (state_q == ST_LOAD);
		cmd.step   = (state_q == ST_DIV);
		cmd.save   = (state_q == ST_SAVE);
		cmd.emit   = (state_q == ST_OUT) && status.out_free;
	end

endmodule

### rtl/core/pmcs_dp.sv
// datapath: bin stores, config registers, restoring divider, result register
module pmcs_dp
	import pmcs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  sample_word_t        sample,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data,
	input  ctrl_cmd_t           cmd,
	output dp_status_t          status,
	output logic                result_valid,
	input  logic                result_stall,
	output result_word_t        result
);

	// configuration
	logic signed [THRESH_BITS-1:0] cutoff_q;
	logic [PERIOD_BITS-1:0]        summin_q;
	logic [PERIOD_BITS-1:0]        period_q;

	// bin stores
	logic signed [SAMPLE_BITS-1:0] min_q   [BINS];
	logic signed [SAMPLE_BITS-1:0] max_q   [BINS];
	logic signed [SUM_BITS-1:0]    sum_q   [BINS];
	logic [COUNT_BITS-1:0]         count_q [BINS];
	logic [TIME_BITS-1:0]          first_q [BINS];
	logic                          summary_done_q;
	logic                          due_q;

	// latched sample
	logic [2:0]                    bin_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic [TIME_BITS-1:0]          t_q;

	// captured stats of the sample's bin
	logic signed [SAMPLE_BITS-1:0] smin_q;
	logic signed [SAMPLE_BITS-1:0] smax_q;
	logic [COUNT_BITS-1:0]         scount_q;
	logic [TIME_BITS-1:0]          sfirst_q;
	logic [DUR_BITS-1:0]           dur_q;

	// divider
	logic [COUNT_BITS-1:0]         rem_q;
	logic [COUNT_BITS-1:0]         div_q;
	logic [SAMPLE_BITS-1:0]        dvd_q;
	logic                          neg_q;
	logic                          zero_q;
	logic signed [SAMPLE_BITS-1:0] avg_q [4];

	logic                          result_valid_q;
	result_word_t                  result_q;

	// read port into the stores, indexed by the divider slot
	logic [2:0]                    rd_idx;
	logic signed [SAMPLE_BITS-1:0] rd_min;
	logic signed [SAMPLE_BITS-1:0] rd_max;
	logic signed [SUM_BITS-1:0]    rd_sum;
	logic [COUNT_BITS-1:0]         rd_count;
	logic [TIME_BITS-1:0]          rd_first;
	logic [COUNT_BITS-1:0]         new_count;
	logic                          due_now;
	logic [SUM_BITS-1:0]           sum_mag;
	logic [COUNT_BITS:0]           trial;
	logic [COUNT_BITS:0]           trial_diff;
	logic                          qbit;
	logic signed [SAMPLE_BITS-1:0] avg_now;
	logic [DUR_BITS+PERIOD_BITS-1:0] prod;

	always_comb begin
		case (cmd.slot)
			SLOT_LP: rd_idx = CAT_LOW_POWER;
			SLOT_HD: rd_idx = CAT_HEAD_DOWN;
			SLOT_AC: rd_idx = CAT_ACTIVE;
			default: rd_idx = bin_q;
		endcase
	end

	assign rd_min    = min_q[rd_idx];
	assign rd_max    = max_q[rd_idx];
	assign rd_sum    = sum_q[rd_idx];
	assign rd_count  = count_q[rd_idx];
	assign rd_first  = first_q[rd_idx];
	assign new_count = (rd_count != COUNT_MAX) ? rd_count + 1'b1 : rd_count;
	assign due_now   = (bin_q == CAT_LOW_POWER) && !summary_done_q &&
		(new_count >= COUNT_BITS'(summin_q));
	assign sum_mag   = rd_sum[SUM_BITS-1] ? SUM_BITS'(-rd_sum) : SUM_BITS'(rd_sum);
	assign prod      = DUR_BITS'(rd_count) * period_q;

	assign trial      = {rem_q, dvd_q[SAMPLE_BITS-1]};
	assign trial_diff = trial - {1'b0, div_q};
	assign qbit       = (trial >= {1'b0, div_q});
	assign avg_now    = zero_q ? '0 :
		(neg_q ? SAMPLE_BITS'(-dvd_q) : SAMPLE_BITS'(dvd_q));

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= CUTOFF_RESET;
			summin_q <= SUMMIN_RESET;
			period_q <= PERIOD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CUTOFF: cutoff_q <= THRESH_BITS'(cfg_data);
				REG_SUMMIN: summin_q <= PERIOD_BITS'(cfg_data);
				REG_PERIOD: period_q <= PERIOD_BITS'(cfg_data);
				default: ;
			endcase
		end
	end

	// bin stores and summary flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BINS; i++) begin
				min_q[i]   <= '0;
				max_q[i]   <= '0;
				sum_q[i]   <= '0;
				count_q[i] <= '0;
				first_q[i] <= '0;
			end
			summary_done_q <= 1'b0;
			due_q          <= 1'b0;
		end else if (cmd.update) begin
			if (rd_count == '0) begin
				min_q[bin_q]   <= x_q;
				max_q[bin_q]   <= x_q;
				first_q[bin_q] <= t_q;
			end else begin
				if (x_q < rd_min) min_q[bin_q] <= x_q;
				if (x_q > rd_max) max_q[bin_q] <= x_q;
			end
			if (rd_count != COUNT_MAX) begin
				sum_q[bin_q]   <= rd_sum + SUM_BITS'(x_q);
				count_q[bin_q] <= new_count;
			end
			due_q <= due_now;
			if (due_now) summary_done_q <= 1'b1;
		end
	end

	// sample latch, bin capture, divider
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			bin_q <= pick_bin(sample.system_mode, sample.head_lowered);
			x_q   <= sample.current_sample;
			t_q   <= sample.time_ms;
		end
		if (cmd.load) begin
			rem_q  <= sum_mag[SUM_BITS-1:SAMPLE_BITS];
			dvd_q  <= sum_mag[SAMPLE_BITS-1:0];
			div_q  <= rd_count;
			neg_q  <= rd_sum[SUM_BITS-1];
			zero_q <= (rd_count == '0);
			if (cmd.slot == SLOT_BIN) begin
				smin_q   <= rd_min;
				smax_q   <= rd_max;
				scount_q <= rd_count;
				sfirst_q <= rd_first;
				dur_q    <= prod[DUR_BITS-1:0];
			end
		end
		if (cmd.step) begin
			rem_q <= qbit ? trial_diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
			dvd_q <= {dvd_q[SAMPLE_BITS-2:0], qbit};
		end
		if (cmd.save) begin
			avg_q[cmd.slot] <= avg_now;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.category     <= bin_q;
			result_q.bin_min      <= smin_q;
			result_q.bin_max      <= smax_q;
			result_q.bin_average  <= avg_q[SLOT_BIN];
			result_q.bin_count    <= scount_q;
			result_q.duration_ms  <= dur_q;
			result_q.first_time   <= sfirst_q;
			result_q.summary_due  <= due_q;
			result_q.cutoff_known <= (count_q[CAT_LOW_POWER] != '0);
			result_q.lp_cutoff_ok <= (count_q[CAT_LOW_POWER] != '0) &&
				(avg_q[SLOT_LP] < cutoff_q);
			result_q.mute_known   <= (count_q[CAT_ACTIVE] != '0) &&
				(count_q[CAT_HEAD_DOWN] != '0);
			result_q.mute_pass    <= (count_q[CAT_ACTIVE] != '0) &&
				(count_q[CAT_HEAD_DOWN] != '0) && (avg_q[SLOT_HD] < avg_q[SLOT_AC]);
		end
	end

	assign status.out_free = !result_valid_q || !result_stall;
	assign result_valid    = result_valid_q;
	assign result          = result_q;

	// a loaded word always shows up on the result port
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> result_valid)
		else $error("result word lost after load");

	// partial remainder stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (zero_q || rem_q < div_q))
		else $error("divider remainder out of range");

	// the summary flag is one-shot
	a_summary_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(summary_done_q) |-> summary_done_q)
		else $error("summary flag cleared");

endmodule

### rtl/core/per_mode_current_statistics.sv
// top level of the per-mode current statistics block
//
//  channel   dir  handshake                      word
//  sample    in   sample_valid / sample_stall    sample_word_t
//  result    out  result_valid / result_stall    result_word_t
//  cfg       in   cfg_we, cfg_index, cfg_data    write only, no wait
//
// a sample passes through update, then load, divide and save for each of four slots, then output
// the shared restoring divider computes the four averages, one quotient bit a cycle
// one sample at a time; sample_stall is high from accept until its result is loaded
// a result waiting under result_stall does not block the next sample's accept
// reset clears all bins, the summary flag and loads the register defaults
module per_mode_current_statistics
	import pmcs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// sample channel
	input  logic                sample_valid,
	output logic                sample_stall,
	input  sample_word_t        sample,
	// result channel
	output logic                result_valid,
	input  logic                result_stall,
	output result_word_t        result,
	// configuration writes
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data
);

	// command and status between sequencer and datapath
	ctrl_cmd_t  cmd;
	dp_status_t status;

	// sequencer: owns the sample handshake and the divider step count
	pmcs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.status       (status),
		.cmd          (cmd)
	);

	// datapath: stores, divider and the output register
	pmcs_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample       (sample),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

### tb/pmcs_checker.sv
`timescale 1ns / 100ps
// checker for the per-mode current statistics block: bin model, result queue and comparison
module pmcs_checker
	import pmcs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	input  logic                sample_stall,
	input  sample_word_t        sample,
	input  logic                result_valid,
	input  logic                result_stall,
	input  result_word_t        result,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data,
	output int                  failures,
	output int                  pending
);

	// per-bin history, kept wide so sums and products never wrap
	longint                 low_seen   [BINS];
	longint                 high_seen  [BINS];
	longint                 bin_total  [BINS];
	longint                 bin_tally  [BINS];
	logic [TIME_BITS-1:0]   bin_first  [BINS];
	bit                     summary_sent;

	logic signed [THRESH_BITS-1:0] cutoff_reg;
	logic [PERIOD_BITS-1:0]        summin_reg;
	logic [PERIOD_BITS-1:0]        period_reg;

	result_word_t stats_due[$];

	function automatic logic [2:0] bin_of(input logic [2:0] mode, input logic head);
		case (mode)
			MODE_MUTED: return CAT_MUTED;
			MODE_LOW:   return CAT_LOW_POWER;
			MODE_DIAG:  return CAT_DIAG;
			MODE_FAULT: return CAT_FAULT;
			default:    return head ? CAT_HEAD_DOWN : CAT_ACTIVE;
		endcase
	endfunction

	// truncating mean, zero for an empty bin
	function automatic longint bin_mean(input int b);
		if (bin_tally[b] == 0)
			return 0;
		return bin_total[b] / bin_tally[b];
	endfunction

	task automatic absorb_sample(input sample_word_t w);
		logic [2:0]   cat;
		longint       x;
		result_word_t stats;
		cat   = bin_of(w.system_mode, w.head_lowered);
		x     = w.current_sample;
		stats = '0;
		if (bin_tally[cat] == 0) begin
			low_seen[cat]  = x;
			high_seen[cat] = x;
			bin_first[cat] = w.time_ms;
		end else begin
			if (x < low_seen[cat])
				low_seen[cat] = x;
			if (x > high_seen[cat])
				high_seen[cat] = x;
		end
		// a saturated count freezes the sum as well
		if (bin_tally[cat] < longint'(COUNT_MAX)) begin
			bin_total[cat] += x;
			bin_tally[cat]++;
		end
		if (cat == CAT_LOW_POWER && !summary_sent && bin_tally[cat] >= longint'(summin_reg)) begin
			stats.summary_due = 1'b1;
			summary_sent      = 1'b1;
		end
		if (bin_tally[CAT_LOW_POWER] != 0) begin
			stats.cutoff_known = 1'b1;
			stats.lp_cutoff_ok = bin_mean(CAT_LOW_POWER) < longint'(cutoff_reg);
		end
		if (bin_tally[CAT_ACTIVE] != 0 && bin_tally[CAT_HEAD_DOWN] != 0) begin
			stats.mute_known = 1'b1;
			stats.mute_pass  = bin_mean(CAT_HEAD_DOWN) < bin_mean(CAT_ACTIVE);
		end
		stats.category    = cat;
		stats.bin_min     = SAMPLE_BITS'(low_seen[cat]);
		stats.bin_max     = SAMPLE_BITS'(high_seen[cat]);
		stats.bin_average = SAMPLE_BITS'(bin_mean(cat));
		stats.bin_count   = COUNT_BITS'(bin_tally[cat]);
		stats.duration_ms = DUR_BITS'(bin_tally[cat] * longint'(period_reg));
		stats.first_time  = bin_first[cat];
		stats_due.push_back(stats);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			failures++;
			if (failures <= 10)
				$display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
		end
	endtask

	task automatic check_result(input result_word_t want, input result_word_t got);
		check_field("category", want.category, got.category);
		check_field("bin_min", want.bin_min, got.bin_min);
		check_field("bin_max", want.bin_max, got.bin_max);
		check_field("bin_average", want.bin_average, got.bin_average);
		check_field("bin_count", want.bin_count, got.bin_count);
		check_field("duration_ms", want.duration_ms, got.duration_ms);
		check_field("first_time", want.first_time, got.first_time);
		check_field("summary_due", want.summary_due, got.summary_due);
		check_field("cutoff_known", want.cutoff_known, got.cutoff_known);
		check_field("lp_cutoff_ok", want.lp_cutoff_ok, got.lp_cutoff_ok);
		check_field("mute_known", want.mute_known, got.mute_known);
		check_field("mute_pass", want.mute_pass, got.mute_pass);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < BINS; b++) begin
				low_seen[b]  = 0;
				high_seen[b] = 0;
				bin_total[b] = 0;
				bin_tally[b] = 0;
				bin_first[b] = '0;
			end
			summary_sent = 1'b0;
			cutoff_reg   = CUTOFF_RESET;
			summin_reg   = SUMMIN_RESET;
			period_reg   = PERIOD_RESET;
			stats_due.delete();
			failures     = 0;
			pending      = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CUTOFF: cutoff_reg = cfg_data[THRESH_BITS-1:0];
					REG_SUMMIN: summin_reg = cfg_data[PERIOD_BITS-1:0];
					REG_PERIOD: period_reg = cfg_data[PERIOD_BITS-1:0];
					default: ;
				endcase
			end
			if (result_valid && !result_stall) begin
				if (stats_due.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("%0t: result word with nothing expected: %h", $realtime, result);
				end else begin
					check_result(stats_due.pop_front(), result);
				end
			end
			if (sample_valid && !sample_stall)
				absorb_sample(sample);
			pending = stats_due.size();
		end
	end

endmodule

### tb/per_mode_current_statistics_test.sv
`timescale 1ns / 100ps
// top of the per-mode current statistics testbench: clock, reset, stimulus and verdict
module per_mode_current_statistics_test;
	import pmcs_pkg::*;

	// index that maps to no register, the block must ignore writes to it
	localparam logic [1:0] REG_SPARE = 2'd3;

	localparam int RANDOM_PHASES   = 5;
	localparam int WORDS_PER_PHASE = 130;
	localparam int HOLD_CYCLES     = 1500;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                sample_valid = 1'b0;
	logic                sample_stall;
	sample_word_t        sample       = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	result_word_t        result;
	logic                cfg_we       = 1'b0;
	logic [1:0]          cfg_index    = '0;
	logic [CFG_BITS-1:0] cfg_data     = '0;

	int failures;
	int pending;

	// idling knobs, percent per cycle
	int idle_pct  = 0;
	int stall_pct = 0;
	// one-shot request for a long receiver hold-off
	bit hold_go   = 1'b0;

	per_mode_current_statistics u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	pmcs_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.failures     (failures),
		.pending      (pending)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	// receiver side: random stall, or a counted hold-off when asked for
	initial begin
		int hold_left;
		bit hold_used;
		hold_left = 0;
		hold_used = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go && !hold_used) begin
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// generous fixed limit, well past the slowest correct run
	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic sample_word_t make_word(input logic [2:0] mode, input logic head,
			input logic signed [SAMPLE_BITS-1:0] current, input logic [TIME_BITS-1:0] stamp);
		sample_word_t w;
		w.system_mode    = mode;
		w.head_lowered   = head;
		w.current_sample = current;
		w.time_ms        = stamp;
		return w;
	endfunction

	// mostly small currents so the averages sit near the cutoff and each other,
	// now and then a full-range or extreme one
	function automatic sample_word_t random_word();
		logic signed [SAMPLE_BITS-1:0] current;
		case ($urandom_range(15))
			0:       current = SAMPLE_BITS'($urandom);
			1:       current = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			2:       current = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			default: current = SAMPLE_BITS'(int'($urandom_range(1000)) - 500);
		endcase
		return make_word(3'($urandom_range(7)), 1'($urandom_range(1)), current, $urandom);
	endfunction

	// offer one word, idling first at the current rate, and wait for its accept
	task automatic send_word(input sample_word_t w);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample       <= w;
		sample_valid <= 1'b1;
		do
			@(posedge clk);
		while (sample_stall);
	endtask

	// drop valid and wait until every expected result word is back
	task automatic drain();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_BITS-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		logic [CFG_BITS-1:0] cutoff_val;
		logic [CFG_BITS-1:0] summin_val;
		logic [CFG_BITS-1:0] period_val;
		int                  phase_idle;
		int                  phase_stall;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// zero summary threshold: the first low-power word raises the flag
		write_reg(REG_SUMMIN, '0);

		// directed words, default cutoff and period
		send_word(make_word(MODE_LOW, 1'b0, 24'sd50, 32'h0000_0000));
		send_word(make_word(MODE_LOW, 1'b0, 24'sh800000, 32'hFFFF_FFFF));
		send_word(make_word(MODE_LOW, 1'b1, 24'sh7FFFFF, 32'h0000_0001));
		// active bin at the top, head-down bin at the bottom: mute check known
		send_word(make_word(CAT_ACTIVE, 1'b0, 24'sh7FFFFF, 32'hFFFF_FFFF));
		send_word(make_word(CAT_ACTIVE, 1'b1, 24'sh800000, 32'h0000_0000));
		send_word(make_word(MODE_MUTED, 1'b0, -24'sd1, 32'h0000_0005));
		// negative sum with a remainder: average truncates toward zero
		send_word(make_word(MODE_MUTED, 1'b1, -24'sd6, 32'h0000_0006));
		send_word(make_word(MODE_DIAG, 1'b1, 24'sd0, 32'hAAAA_AAAA));
		send_word(make_word(MODE_DIAG, 1'b0, -24'sd3, 32'h5555_5555));
		send_word(make_word(MODE_FAULT, 1'b1, 24'sd1, 32'h1234_5678));
		send_word(make_word(MODE_FAULT, 1'b0, 24'sd2, 32'h8765_4321));
		// modes above fault fall into the active or head-down bins
		send_word(make_word(3'd5, 1'b0, -24'sd100, 32'h0000_0010));
		send_word(make_word(3'd6, 1'b1, 24'sd300, 32'h0000_0011));
		send_word(make_word(3'd7, 1'b0, 24'sd0, 32'h0000_0012));
		send_word(make_word(3'd7, 1'b1, -24'sd200, 32'h0000_0013));
		send_word(make_word(CAT_ACTIVE, 1'b0, 24'sh800000, 32'h0000_0014));
		send_word(make_word(MODE_LOW, 1'b0, -24'sd1, 32'h0000_0015));
		drain();

		// a write to the spare index must change nothing
		write_reg(REG_SPARE, 24'hFFFFFF);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			// registers change only with the block idle
			case (p)
				0: begin
					cutoff_val  = 24'h7FFFFF;
					summin_val  = 24'h00FFFF;
					period_val  = 24'h00FFFF;
					phase_idle  = 0;
					phase_stall = 0;
				end
				1: begin
					cutoff_val  = 24'h800000;
					summin_val  = 24'h000001;
					period_val  = 24'h000001;
					phase_idle  = 58;
					phase_stall = 0;
				end
				2: begin
					cutoff_val  = '0;
					summin_val  = CFG_BITS'($urandom_range(65535, 1));
					period_val  = CFG_BITS'($urandom_range(65535, 1));
					phase_idle  = 0;
					phase_stall = 58;
				end
				3: begin
					cutoff_val  = CFG_BITS'(int'($urandom_range(400)) - 200);
					summin_val  = CFG_BITS'(SUMMIN_RESET);
					period_val  = CFG_BITS'($urandom_range(65535, 1));
					phase_idle  = 19;
					phase_stall = 19;
				end
				default: begin
					cutoff_val  = CFG_BITS'(CUTOFF_RESET);
					summin_val  = CFG_BITS'($urandom_range(65535, 1));
					period_val  = CFG_BITS'(PERIOD_RESET);
					phase_idle  = 0;
					phase_stall = 0;
				end
			endcase
			write_reg(REG_CUTOFF, cutoff_val);
			write_reg(REG_SUMMIN, summin_val);
			write_reg(REG_PERIOD, period_val);
			// last phase: receiver holds off while words keep coming, so the input backs up
			if (p == RANDOM_PHASES - 1)
				hold_go = 1'b1;
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				// short bursts with no idling at all inside every phase
				if (n % 40 >= 20 && n % 40 < 26) begin
					idle_pct  = 0;
					stall_pct = 0;
				end else begin
					idle_pct  = phase_idle;
					stall_pct = phase_stall;
				end
				send_word(random_word());
			end
			drain();
		end

		// tail: room for a stray word well past the block latency
		repeat (200) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
